// File: rtl/multi_channel_soft_watchdog_defines.svh
// Assertion macros used by the watchdog checker
`ifndef MULTI_CHANNEL_SOFT_WATCHDOG_DEFINES_SVH
`define MULTI_CHANNEL_SOFT_WATCHDOG_DEFINES_SVH

// Clocked assertion, off while reset is asserted
`define MCSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define MCSW_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mcsw_pkg.sv
// Types and constants of the multi-channel soft watchdog
`default_nettype none

package mcsw_pkg;

  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned TMO_W    = 24;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned OUT_T_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // transaction modes
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_FEED     = 3'd1;
  localparam logic [2:0] MODE_START    = 3'd2;
  localparam logic [2:0] MODE_STOP     = 3'd3;
  localparam logic [2:0] MODE_APPLY    = 3'd4;
  localparam logic [2:0] MODE_UPG_ON   = 3'd5;
  localparam logic [2:0] MODE_UPG_OFF  = 3'd6;

  // channel codes
  localparam logic [1:0] CH_SYS     = 2'd0;
  localparam logic [1:0] CH_UPG     = 2'd1;
  localparam logic [1:0] CH_COMM    = 2'd2;
  localparam logic [1:0] CH_INVALID = 2'd3;

  // channel states
  localparam logic [1:0] ST_DISABLED  = 2'd0;
  localparam logic [1:0] ST_ENABLED   = 2'd1;
  localparam logic [1:0] ST_TRIGGERED = 2'd2;

  // protection levels
  localparam logic [1:0] LVL_BASIC      = 2'd0;
  localparam logic [1:0] LVL_STANDARD   = 2'd1;
  localparam logic [1:0] LVL_AUTOMOTIVE = 2'd2;
  localparam logic [1:0] LVL_INVALID    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_TMO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPG_TMO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPG_EXT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_TMO = 3'd4;

  // configuration reset values
  localparam logic [TMO_W-1:0] RST_SYS_TMO = 24'd3000;
  localparam logic [TMO_W-1:0] RST_UPG_TMO = 24'd30000;
  localparam logic [TMO_W-1:0] RST_UPG_EXT = 24'd60000;
  localparam logic [TMO_W-1:0] RST_COM_TMO = 24'd5000;

  typedef struct packed {
    logic [2:0]       mode;
    logic [1:0]       channel;
    logic [TMO_W-1:0] arm_ms;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [2:0]         fired_mask;
    logic [1:0]         system_state;
    logic [1:0]         upgrade_state;
    logic [1:0]         comm_state;
    logic [CNT_W-1:0]   sel_trigger_count;
    logic [OUT_T_W-1:0] sel_last_feed;
    logic               upgrade_active;
    logic               hw_refresh;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       protection_level;
    logic [TMO_W-1:0] system_timeout_ms;
    logic [TMO_W-1:0] upgrade_timeout_ms;
    logic [TMO_W-1:0] upgrade_extended_ms;
    logic [TMO_W-1:0] comm_timeout_ms;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/mcsw_cfg.sv
// Configuration register file of the watchdog
`default_nettype none

module mcsw_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [mcsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mcsw_pkg::TMO_W-1:0]     cfg_wdata,
  output mcsw_pkg::cfg_t                      cfg
);
  import mcsw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEVEL:   cfg_nxt.protection_level    = cfg_wdata[1:0];
        CFG_SYS_TMO: cfg_nxt.system_timeout_ms   = cfg_wdata;
        CFG_UPG_TMO: cfg_nxt.upgrade_timeout_ms  = cfg_wdata;
        CFG_UPG_EXT: cfg_nxt.upgrade_extended_ms = cfg_wdata;
        CFG_COM_TMO: cfg_nxt.comm_timeout_ms     = cfg_wdata;
        default:     cfg_nxt = cfg_r; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protection_level    <= LVL_AUTOMOTIVE;
      cfg_r.system_timeout_ms   <= RST_SYS_TMO;
      cfg_r.upgrade_timeout_ms  <= RST_UPG_TMO;
      cfg_r.upgrade_extended_ms <= RST_UPG_EXT;
      cfg_r.comm_timeout_ms     <= RST_COM_TMO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/mcsw_core.sv
// Channel state and per-transaction update logic of the watchdog
`default_nettype none

module mcsw_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire mcsw_pkg::in_item_t item,
  input  wire mcsw_pkg::cfg_t     cfg,
  output mcsw_pkg::out_item_t     result
);
  import mcsw_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

  logic [TIME_BITS-1:0] now_r,  now_nxt;
  logic [1:0]           state_r [NUM_CHAN];
  logic [1:0]           state_nxt [NUM_CHAN];
  logic [TMO_W-1:0]     tmo_r [NUM_CHAN];
  logic [TMO_W-1:0]     tmo_nxt [NUM_CHAN];
  logic [TIME_BITS-1:0] last_r [NUM_CHAN];
  logic [TIME_BITS-1:0] last_nxt [NUM_CHAN];
  logic [CNT_W-1:0]     cnt_r [NUM_CHAN];
  logic [CNT_W-1:0]     cnt_nxt [NUM_CHAN];
  logic                 upg_r, upg_nxt;

  logic [TIME_BITS-1:0] now_inc;
  logic [TIME_BITS-1:0] elapsed [NUM_CHAN];
  logic [TMO_W-1:0]     lvl_tmo [NUM_CHAN];
  logic                 ch_ok;
  logic [1:0]           ch;
  logic                 status;
  logic [2:0]           fired;
  logic                 refresh;

  assign now_inc = now_r + TIME_BITS'(1);
  assign ch      = item.channel;
  assign ch_ok   = (item.channel != CH_INVALID);

  assign lvl_tmo[0] = cfg.system_timeout_ms;
  assign lvl_tmo[1] = cfg.upgrade_timeout_ms;
  assign lvl_tmo[2] = cfg.comm_timeout_ms;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      elapsed[c] = now_inc - last_r[c];
    end
  end

  always_comb begin
    now_nxt = now_r;
    upg_nxt = upg_r;
    status  = 1'b0;
    fired   = '0;
    refresh = 1'b0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      state_nxt[c] = state_r[c];
      tmo_nxt[c]   = tmo_r[c];
      last_nxt[c]  = last_r[c];
      cnt_nxt[c]   = cnt_r[c];
    end

    unique case (item.mode)
      MODE_TICK: begin
        now_nxt = now_inc;
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (state_r[c] == ST_ENABLED &&
              CMP_W'(elapsed[c]) >= CMP_W'(tmo_r[c])) begin
            state_nxt[c] = ST_TRIGGERED;
            cnt_nxt[c]   = cnt_r[c] + CNT_W'(1);
            fired[c]     = 1'b1;
          end
        end
      end
      MODE_FEED: begin
        if (!ch_ok || state_r[ch] != ST_ENABLED) begin
          status = 1'b1;
        end else begin
          last_nxt[ch] = now_r;
          refresh      = (ch == CH_SYS);
        end
      end
      MODE_START: begin
        if (!ch_ok) begin
          status = 1'b1;
        end else begin
          state_nxt[ch] = ST_ENABLED;
          tmo_nxt[ch]   = item.arm_ms;
          last_nxt[ch]  = now_r;
          cnt_nxt[ch]   = '0;
        end
      end
      MODE_STOP: begin
        if (!ch_ok) begin
          status = 1'b1;
        end else begin
          state_nxt[ch] = ST_DISABLED;
        end
      end
      MODE_APPLY: begin
        if (cfg.protection_level > LVL_AUTOMOTIVE) begin
          status = 1'b1;
        end else begin
          // arm every channel up to the level, clear the rest
          for (int c = 0; c < NUM_CHAN; c++) begin
            if (2'(c) <= cfg.protection_level) begin
              state_nxt[c] = ST_ENABLED;
              tmo_nxt[c]   = lvl_tmo[c];
              last_nxt[c]  = now_r;
            end else begin
              state_nxt[c] = ST_DISABLED;
              tmo_nxt[c]   = '0;
              last_nxt[c]  = '0;
            end
            cnt_nxt[c] = '0;
          end
        end
      end
      MODE_UPG_ON, MODE_UPG_OFF: begin
        upg_nxt = (item.mode == MODE_UPG_ON);
        if (state_r[CH_UPG] == ST_ENABLED) begin
          tmo_nxt[CH_UPG]  = (item.mode == MODE_UPG_ON) ? cfg.upgrade_extended_ms
                                                        : cfg.upgrade_timeout_ms;
          last_nxt[CH_UPG] = now_r;
          cnt_nxt[CH_UPG]  = '0;
        end
      end
      default: status = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      upg_r <= 1'b0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        state_r[c] <= ST_DISABLED;
        tmo_r[c]   <= '0;
        last_r[c]  <= '0;
        cnt_r[c]   <= '0;
      end
    end else if (step) begin
      now_r <= now_nxt;
      upg_r <= upg_nxt;
      for (int c = 0; c < NUM_CHAN; c++) begin
        state_r[c] <= state_nxt[c];
        tmo_r[c]   <= tmo_nxt[c];
        last_r[c]  <= last_nxt[c];
        cnt_r[c]   <= cnt_nxt[c];
      end
    end
  end

  always_comb begin
    result.status            = status;
    result.fired_mask        = fired;
    result.system_state      = state_nxt[CH_SYS];
    result.upgrade_state     = state_nxt[CH_UPG];
    result.comm_state        = state_nxt[CH_COMM];
    result.sel_trigger_count = ch_ok ? cnt_nxt[ch] : '0;
    result.sel_last_feed     = ch_ok ? OUT_T_W'(last_nxt[ch]) : '0;
    result.upgrade_active    = upg_nxt;
    result.hw_refresh        = refresh;
  end

endmodule

`default_nettype wire

// File: rtl/multi_channel_soft_watchdog.sv
// Top level of the multi-channel soft watchdog
//
//   channel   direction  handshake         payload
//   in_       input      in_valid/in_stall   mcsw_pkg::in_item_t
//   out_      output     out_valid/out_stall mcsw_pkg::out_item_t
//   cfg_      input      cfg_wr_en           cfg_index, cfg_wdata
//
// One transaction per cycle unless out_stall holds the pipe: input register,
// then the channel update, then the result register. out_valid rises once the
// transaction has passed the input register and the channel update.
// Reset (rst_n low, synchronous) disables all channels and loads the default
// timeouts; the block takes transactions on the next cycle.
// A stalled result holds the pipe; in_stall is high only while both registers
// are full and out_stall is high.
`default_nettype none

module multi_channel_soft_watchdog #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire mcsw_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output mcsw_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [mcsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mcsw_pkg::TMO_W-1:0]     cfg_wdata
);
  import mcsw_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      s1_go;
  logic      in_take;
  cfg_t      cfg;
  out_item_t result;

  mcsw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mcsw_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // advance the held transaction when the result register is free or draining
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (s1_go) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/mcsw_checker.sv
// Port-level checker of the watchdog and its bind
`default_nettype none
`include "multi_channel_soft_watchdog_defines.svh"

module mcsw_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mcsw_pkg::out_item_t out_data
);
  import mcsw_pkg::*;

  `MCSW_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data),
    "stalled result changed")
  `MCSW_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `MCSW_ASSERT(a_refresh_ok,
    out_valid && out_data.hw_refresh |-> !out_data.status &&
      out_data.fired_mask == 3'b000 && out_data.system_state == ST_ENABLED,
    "refresh without a good system feed")
  `MCSW_ASSERT(a_fired_state,
    out_valid && out_data.fired_mask != 3'b000 |->
      (!out_data.fired_mask[0] || out_data.system_state == ST_TRIGGERED) &&
      (!out_data.fired_mask[1] || out_data.upgrade_state == ST_TRIGGERED) &&
      (!out_data.fired_mask[2] || out_data.comm_state == ST_TRIGGERED),
    "fired channel not triggered")

endmodule

bind multi_channel_soft_watchdog mcsw_checker u_mcsw_checker (.*);

`default_nettype wire
